// ----- design/assert_macros.svh -----
// Assertion macros shared by the complementary tilt filter RTL.
// Depends on nothing; users supply clk_i and rst_ni in their scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock, disabled while the named reset is low.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("Assertion failed.");

// Same, on the module's own clk_i and rst_ni.
`define ASSERT_CLK(lbl, prop) `ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

// ----- design/ctf_pkg.sv -----
// Package for the complementary tilt filter: widths, fixed-point constants,
// the CORDIC arctangent table and the lane status type. Depends on nothing.
`timescale 1ns / 1ps

package ctf_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned MaxTab      = 24;
  localparam int unsigned TabIdxW     = 5;
  localparam int unsigned NumLanes    = 2;

  // CORDIC datapath widths; the angle is in 1/32768 degree.
  localparam int unsigned XyW  = 27;
  localparam int unsigned ZW   = 26;
  localparam int unsigned AngW = 18;

  localparam logic signed [ZW-1:0] ZHalfTurn = 26'sd5898240;

  localparam logic [15:0] GyroWeightReset = 16'd64225;

  // Rounded division by 125000 is a shift by three and a reciprocal multiply by 15625.
  localparam logic [31:0] RoundHalf  = 32'd62500;
  localparam int unsigned DivShift   = 3;
  localparam logic [28:0] RecipMul   = 29'd281474977;
  localparam int unsigned RecipShift = 42;

  localparam logic signed [15:0] AngLimit = 16'sd23040;

  localparam logic [20:0] AtanTab [MaxTab] = '{
    21'd1474560, 21'd870484, 21'd459940, 21'd233473, 21'd117189, 21'd58652,
    21'd29333,   21'd14667,  21'd7334,   21'd3667,   21'd1833,   21'd917,
    21'd458,     21'd229,    21'd115,    21'd57,     21'd29,     21'd14,
    21'd7,       21'd4,      21'd2,      21'd1,      21'd0,      21'd0
  };

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

endpackage

// ----- design/ctf_cordic.sv -----
// Iterative vectoring CORDIC that computes atan2(y, x) in 1/128 degree, one step per cycle.
// Depends on ctf_pkg.
`timescale 1ns / 1ps

module ctf_cordic #(
  parameter int unsigned Steps = ctf_pkg::CordicSteps
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [15:0]             y_i,
  input  logic signed [15:0]             x_i,
  output logic                           done_o,
  output logic signed [ctf_pkg::AngW-1:0] angle_o
);
  import ctf_pkg::*;

  localparam int unsigned CntW = $clog2(Steps);
  localparam logic [CntW-1:0] LastStep = CntW'(Steps - 1);

  logic                  run_q, run_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic signed [XyW-1:0] x_q, y_q;
  logic signed [ZW-1:0]  z_q;
  logic signed [XyW-1:0] x_sc, y_sc, x_ld, y_ld, xs, ys, x_it, y_it;
  logic signed [ZW-1:0]  z_ld, z_it, atan_z, z_rnd;

  always_comb begin
    x_sc = {{(XyW-24){x_i[15]}}, x_i, 8'd0};
    y_sc = {{(XyW-24){y_i[15]}}, y_i, 8'd0};
    if (x_i[15]) begin
      x_ld = -x_sc;
      y_ld = -y_sc;
      z_ld = y_i[15] ? -ZHalfTurn : ZHalfTurn;
    end else begin
      x_ld = x_sc;
      y_ld = y_sc;
      z_ld = '0;
    end
  end

  always_comb begin
    xs     = x_q >>> cnt_q;
    ys     = y_q >>> cnt_q;
    atan_z = ZW'(AtanTab[TabIdxW'(cnt_q)]);
    if (!y_q[XyW-1]) begin
      x_it = x_q + ys;
      y_it = y_q - xs;
      z_it = z_q + atan_z;
    end else begin
      x_it = x_q - ys;
      y_it = y_q + xs;
      z_it = z_q - atan_z;
    end
  end

  assign done_o  = run_q && (cnt_q == LastStep);
  assign z_rnd   = z_q + ZW'(128);
  assign angle_o = z_rnd[ZW-1:8];

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
    end else if (run_q) begin
      if (cnt_q == LastStep) begin
        run_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_ld;
      y_q <= y_ld;
      z_q <= z_ld;
    end else if (run_q) begin
      x_q <= x_it;
      y_q <= y_it;
      z_q <= z_it;
    end
  end

endmodule

// ----- design/ctf_lane.sv -----
// One filter lane: gyro advance, accelerometer tilt by CORDIC, weighted blend
// and the kept estimate for one axis. Depends on ctf_pkg and ctf_cordic.
`timescale 1ns / 1ps

module ctf_lane #(
  parameter int unsigned Steps = ctf_pkg::CordicSteps
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      ack_i,
  input  logic [15:0]               weight_i,
  input  logic signed [15:0]        rate_i,
  input  logic signed [15:0]        y_i,
  input  logic signed [15:0]        x_i,
  input  logic [15:0]               dt_i,
  output logic signed [15:0]        est_o,
  output ctf_pkg::lane_stat_t       stat_o
);
  import ctf_pkg::*;

  typedef enum logic [5:0] {
    L_IDLE = 6'b000001,
    L_ITER = 6'b000010,
    L_MULG = 6'b000100,
    L_MULA = 6'b001000,
    L_SUM  = 6'b010000,
    L_DONE = 6'b100000
  } lane_state_e;

  localparam logic signed [21:0] LimHi = 22'(AngLimit);
  localparam logic signed [21:0] LimLo = -LimHi;

  lane_state_e state_q, state_d;
  logic signed [15:0] est_q, est_d;

  logic                   cordic_done;
  logic signed [AngW-1:0] acc_angle;

  logic signed [15:0] rate_q;
  logic [15:0]        dt_q;
  logic signed [32:0] prod_q, mag;
  logic [31:0]        num;
  logic [28:0]        m_d, m_q;
  logic               neg1_q, neg2_q;
  logic [57:0]        quo_full;
  logic [14:0]        quo_q;
  logic signed [16:0] adv, g_d, g_q;
  logic [16:0]        acc_w;
  logic signed [33:0] pg_d, pg_q;
  logic signed [35:0] pa_d, pa_q;
  logic signed [37:0] sum;
  logic signed [21:0] blended;

  ctf_cordic #(
    .Steps(Steps)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .y_i    (y_i),
    .x_i    (x_i),
    .done_o (cordic_done),
    .angle_o(acc_angle)
  );

  // The gyro advance pipeline runs freely and settles long before the CORDIC finishes.
  always_comb begin
    mag      = prod_q[32] ? -prod_q : prod_q;
    num      = mag[31:0] + RoundHalf;
    m_d      = 29'(num >> DivShift);
    quo_full = m_q * RecipMul;
    adv      = neg2_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    g_d      = $signed({est_q[15], est_q}) + adv;
    acc_w    = 17'(18'd65536 - {2'b00, weight_i});
    pg_d     = $signed({1'b0, weight_i}) * g_q;
    pa_d     = $signed({1'b0, acc_w}) * acc_angle;
    sum      = 38'(pg_q) + 38'(pa_q) + 38'sd32768;
    blended  = sum[37:16];
  end

  always_comb begin
    if (blended > LimHi) begin
      est_d = LimHi[15:0];
    end else if (blended < LimLo) begin
      est_d = LimLo[15:0];
    end else begin
      est_d = blended[15:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          state_d = L_ITER;
        end
      end
      L_ITER: begin
        if (cordic_done) begin
          state_d = L_MULG;
        end
      end
      L_MULG: state_d = L_MULA;
      L_MULA: state_d = L_SUM;
      L_SUM:  state_d = L_DONE;
      L_DONE: begin
        if (ack_i) begin
          state_d = L_IDLE;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      est_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == L_SUM) begin
        est_q <= est_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rate_q <= rate_i;
      dt_q   <= dt_i;
    end
    prod_q <= rate_q * $signed({1'b0, dt_q});
    neg1_q <= prod_q[32];
    m_q    <= m_d;
    neg2_q <= neg1_q;
    quo_q  <= quo_full[RecipShift +: 15];
    g_q    <= g_d;
    if (state_q == L_MULG) begin
      pg_q <= pg_d;
    end
    if (state_q == L_MULA) begin
      pa_q <= pa_d;
    end
  end

  assign est_o       = est_q;
  assign stat_o.idle = (state_q == L_IDLE);
  assign stat_o.done = (state_q == L_DONE);

endmodule

// ----- design/complementary_tilt_filter_core.sv -----
// Complementary pitch and roll filter: a pitch lane and a roll lane run side by side.
// Each lane runs its CORDIC loop, one step per cycle, then MULG, MULA and SUM, and holds
// its result in DONE until the output register is free. One item is in flight; a new one
// is taken only when both lanes are idle. Reset clears both estimates to zero, loads the
// gyro weight with 64225 and empties the output register. Depends on ctf_pkg and ctf_lane.
`timescale 1ns / 1ps

module complementary_tilt_filter_core #(
  parameter int unsigned CORDIC_STEPS = ctf_pkg::CordicSteps
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,     // gyro_weight
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // gyro_pitch_rate, gyro_roll_rate, accel_x, accel_y, accel_z, elapsed_time
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // pitch_out, roll_out
);
  import ctf_pkg::*;

  `include "assert_macros.svh"

  logic [15:0]        weight_q;
  logic               start;
  logic               merge_go;
  logic               out_valid_q;
  logic [31:0]        out_q;
  logic signed [15:0] lane_rate [NumLanes];
  logic signed [15:0] lane_y    [NumLanes];
  logic signed [15:0] lane_est  [NumLanes];
  lane_stat_t         lane_stat [NumLanes];

  assign cfg_ready_o = 1'b1;

  // Pitch uses atan2(accel_y, accel_z), roll uses atan2(accel_x, accel_z).
  assign lane_rate[0] = s_axis_tdata[15:0];
  assign lane_rate[1] = s_axis_tdata[31:16];
  assign lane_y[0]    = s_axis_tdata[63:48];
  assign lane_y[1]    = s_axis_tdata[47:32];

  assign s_axis_tready = lane_stat[0].idle && lane_stat[1].idle;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign merge_go      = lane_stat[0].done && lane_stat[1].done &&
                         (!out_valid_q || m_axis_tready);

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    ctf_lane #(
      .Steps(CORDIC_STEPS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (start),
      .ack_i   (merge_go),
      .weight_i(weight_q),
      .rate_i  (lane_rate[l]),
      .y_i     (lane_y[l]),
      .x_i     (s_axis_tdata[79:64]),
      .dt_i    (s_axis_tdata[95:80]),
      .est_o   (lane_est[l]),
      .stat_o  (lane_stat[l])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= GyroWeightReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        weight_q <= cfg_data_i;
      end
      if (merge_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge_go) begin
      out_q <= {lane_est[1], lane_est[0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  `ASSERT_CLK(a_lanes_lockstep, lane_stat[0] == lane_stat[1])
  `ASSERT_CLK(a_one_item_in_flight, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `ASSERT_CLK(a_out_in_range, m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= AngLimit && $signed(m_axis_tdata[15:0]) >= -AngLimit && $signed(m_axis_tdata[31:16]) <= AngLimit && $signed(m_axis_tdata[31:16]) >= -AngLimit))

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for complementary_tilt_filter_core: a directed table, then random
// IMU samples under several weights and handshake stall patterns, checked by a local predictor.
// Depends on ctf_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned FilterSteps = ctf_pkg::CordicSteps;
  localparam int unsigned WatchLimit  = 5000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned PhaseItems  = 220;
  localparam int unsigned SettleWait  = 30;

  typedef struct packed {
    logic [15:0]        elapsed;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_rate;
  } imu_sample_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } attitude_t;

  typedef struct packed {
    logic               new_w;
    logic [15:0]        w;
    logic signed [15:0] rp;
    logic signed [15:0] rr;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [15:0]        dt;
    logic               typed;
    logic signed [15:0] ep;
    logic signed [15:0] er;
  } sample_row_t;

  localparam sample_row_t DirectedRows [23] = '{
    '{0, 0,         0,      0,      0,      0,      0,      0, 1, 256, 256},
    '{0, 0,     32767,  32767,      0,      0,      0,  65535, 0, 0, 0},
    '{0, 0,    -32768, -32768,      0,      0,      0,  65535, 0, 0, 0},
    '{0, 0,         0,      0,      0,   1000,      0,   5000, 0, 0, 0},
    '{0, 0,         0,      0,      0,  -1000,      0,   5000, 0, 0, 0},
    '{0, 0,         0,      0,      0,      0, -16384,   5000, 0, 0, 0},
    '{0, 0,         0,      0,      5,     -5, -16384,   5000, 0, 0, 0},
    '{0, 0,       100,   -100, -32768,  32767,  32767,   5000, 0, 0, 0},
    '{0, 0,      -100,    100,  32767, -32768, -32768,   5000, 0, 0, 0},
    '{0, 0,         1,     -1,     -1,     -1,     -1,      1, 0, 0, 0},
    '{0, 0,     32767, -32768,      0,      0,  16384,  65535, 0, 0, 0},
    '{0, 0,     32767, -32768,      0,      0,  16384,  65535, 0, 0, 0},
    '{0, 0,     32767, -32768,      0,      0,  16384,  65535, 0, 0, 0},
    '{1, 0,     32767,  32767,      0,      0,      0,  65535, 1, 12785, 12785},
    '{0, 0,         0,      0,   -700,   1000,      0,   2000, 0, 0, 0},
    '{0, 0,         0,      0,      0,      0,   -100,   2000, 0, 0, 0},
    '{1, 65535, 32767,  32767,    300,    300,  16000,  65535, 0, 0, 0},
    '{0, 0,     32767,  32767,    300,    300,  16000,  65535, 0, 0, 0},
    '{0, 0,    -32768, -32768,    300,    300,  16000,  65535, 0, 0, 0},
    '{1, 64225,     0,      0,      0,      0,      0,      0, 0, 0, 0},
    '{0, 0,         1,     -1,      0,      0,  16384,  62500, 0, 0, 0},
    '{0, 0,        -1,      1,      0,      0,  16384,  62500, 0, 0, 0},
    '{0, 0,         1,     -1,      0,      0,  16384,  62499, 0, 0, 0}
  };

  localparam logic [63:0] AtanSteps [24] = '{
    64'd1474560, 64'd870484, 64'd459940, 64'd233473, 64'd117189, 64'd58652,
    64'd29333,   64'd14667,  64'd7334,   64'd3667,   64'd1833,   64'd917,
    64'd458,     64'd229,    64'd115,    64'd57,     64'd29,     64'd14,
    64'd7,       64'd4,      64'd2,      64'd1,      64'd0,      64'd0
  };

  localparam logic [15:0] Corners [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

  localparam int InIdlePct [8]  = '{0, 48, 0, 10, 0, 48, 0, 10};
  localparam int OutStallPct [8] = '{0, 0, 48, 10, 0, 0, 48, 10};
  localparam logic [15:0] PhaseWeight [8] = '{
    ctf_pkg::GyroWeightReset, 16'd0, 16'd65535, 16'd0,
    16'd32768, 16'd1, 16'd0, ctf_pkg::GyroWeightReset
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  logic signed [15:0] pitch_est = '0;
  logic signed [15:0] roll_est = '0;
  logic [15:0]        weight_now = ctf_pkg::GyroWeightReset;
  attitude_t          expected_attitude [$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  complementary_tilt_filter_core #(
    .CORDIC_STEPS(FilterSteps)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint tilt_angle(longint num, longint den);
    longint x, y, z, xs, ys;
    x = den * 256;
    y = num * 256;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 180 * 32768 : -180 * 32768;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < FilterSteps && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(AtanSteps[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(AtanSteps[i]);
      end
    end
    return (z + 128) >>> 8;
  endfunction

  function automatic longint gyro_advance(longint rate, longint dt);
    longint p;
    p = rate * dt;
    if (p >= 0) begin
      return (p + 62500) / 125000;
    end
    return -((-p + 62500) / 125000);
  endfunction

  function automatic logic signed [15:0] fuse_angle(longint gyro, longint accel);
    longint w, r;
    w = longint'(weight_now);
    r = (w * gyro + (65536 - w) * accel + 32768) >>> 16;
    if (r > 23040) begin
      r = 23040;
    end
    if (r < -23040) begin
      r = -23040;
    end
    return r[15:0];
  endfunction

  task automatic send_item(input imu_sample_t it, input bit typed, input attitude_t typed_att);
    int unsigned gap;
    attitude_t   nxt;
    gap = 0;
    if ($urandom_range(99) < in_idle_pct) begin
      gap = $urandom_range(1, 25);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    do @(posedge clk_i); while (!s_axis_tready);
    nxt.pitch = fuse_angle(longint'(pitch_est) + gyro_advance(it.pitch_rate, it.elapsed),
                           tilt_angle(it.accel_y, it.accel_z));
    nxt.roll  = fuse_angle(longint'(roll_est) + gyro_advance(it.roll_rate, it.elapsed),
                           tilt_angle(it.accel_x, it.accel_z));
    pitch_est = nxt.pitch;
    roll_est  = nxt.roll;
    expected_attitude.push_back(typed ? typed_att : nxt);
  endtask

  // Stops the sample stream, lets the filter drain and settle, then loads a new weight.
  task automatic retune(input logic [15:0] w);
    s_axis_tvalid <= 1'b0;
    while (expected_attitude.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    weight_now = w;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    attitude_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchLimit) begin
        $display("TB_ERROR");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_attitude.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Unexpected result transaction: pitch %0d roll %0d", got.pitch, got.roll);
          end
        end else begin
          want = expected_attitude.pop_front();
          if (got.pitch !== want.pitch || got.roll !== want.roll) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Mismatch: pitch expected %0d got %0d, roll expected %0d got %0d",
                       want.pitch, got.pitch, want.roll, got.roll);
            end
          end
        end
      end
    end
  end

  initial begin
    imu_sample_t it;
    sample_row_t row;
    attitude_t   att;
    int unsigned pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) begin
      row = DirectedRows[i];
      if (row.new_w) begin
        retune(row.w);
      end
      it.pitch_rate = row.rp;
      it.roll_rate  = row.rr;
      it.accel_x    = row.ax;
      it.accel_y    = row.ay;
      it.accel_z    = row.az;
      it.elapsed    = row.dt;
      att.pitch     = row.ep;
      att.roll      = row.er;
      send_item(it, row.typed, att);
    end

    for (int p = 0; p < 8; p++) begin
      retune((p == 3 || p == 6) ? 16'($urandom) : PhaseWeight[p]);
      in_idle_pct   = InIdlePct[p];
      out_stall_pct = OutStallPct[p];
      if (p == 2) begin
        hold_asked++;
      end
      for (int k = 0; k < PhaseItems; k++) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          it = {$urandom, $urandom, $urandom};
        end else if (pick < 25) begin
          it.pitch_rate = Corners[$urandom_range(4)];
          it.roll_rate  = Corners[$urandom_range(4)];
          it.accel_x    = Corners[$urandom_range(4)];
          it.accel_y    = Corners[$urandom_range(4)];
          it.accel_z    = Corners[$urandom_range(4)];
          it.elapsed    = ($urandom_range(1) == 1) ? Corners[$urandom_range(4)] : 16'd62500;
        end else begin
          it.pitch_rate = 16'($urandom_range(0, 8000) - 4000);
          it.roll_rate  = 16'($urandom_range(0, 8000) - 4000);
          it.accel_x    = 16'($urandom_range(0, 32000) - 16000);
          it.accel_y    = 16'($urandom_range(0, 32000) - 16000);
          it.accel_z    = 16'(16384 + $urandom_range(0, 4000) - 2000);
          if ($urandom_range(9) == 0) begin
            it.accel_z = -it.accel_z;
          end else if ($urandom_range(19) == 0) begin
            it.accel_z = 0;
          end
          it.elapsed    = 16'($urandom_range(1000, 20000));
        end
        send_item(it, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_attitude.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && expected_attitude.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
